/* rtl/core/euler_angles_to_rotation_matrix_defines.svh */
// assertion macros for the roll-pitch-yaw rotation block
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
// implication in the same cycle
`define ERM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// implication in the next cycle
`define ERM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ERM_ASSERT_NOW(lbl, pre, post, msg)
`define ERM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/core/eatrm_pkg.sv */
// shared types, constants and the cordic arctangent table
package eatrm_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int CORDIC_STEPS   = 32;
  localparam int LANES          = 3;
  localparam int XW             = 34;
  localparam int ZW             = 33;
  localparam int OUT_W          = 16;
  localparam logic signed [XW-1:0] INV_GAIN = 34'sd2608131496;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           q;
  } lane_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction
endpackage

/* rtl/core/eatrm_cordic_cell.sv */
// one cordic rotation step for the three angle lanes
module eatrm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eatrm_pkg::lane_t     in_lane [eatrm_pkg::LANES],
  output logic                 out_valid,
  input  logic                 out_ready,
  output eatrm_pkg::lane_t     out_lane [eatrm_pkg::LANES]
);
  import eatrm_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(STEP));

  lane_t lane_next [LANES];

  assign in_ready = !out_valid || out_ready;

  // rotate toward zero residual
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_next[k].q = in_lane[k].q;
      if (in_lane[k].z >= 0) begin
        lane_next[k].x = in_lane[k].x - (in_lane[k].y >>> STEP);
        lane_next[k].y = in_lane[k].y + (in_lane[k].x >>> STEP);
        lane_next[k].z = in_lane[k].z - ATAN;
      end else begin
        lane_next[k].x = in_lane[k].x + (in_lane[k].y >>> STEP);
        lane_next[k].y = in_lane[k].y - (in_lane[k].x >>> STEP);
        lane_next[k].z = in_lane[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_lane <= lane_next;
    end
  end
endmodule

/* rtl/core/eatrm_sincos_fin.sv */
// quadrant fix-up and rounding of the cordic outputs
module eatrm_sincos_fin #(
  parameter int FRAC_BITS = eatrm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  eatrm_pkg::lane_t            in_lane [eatrm_pkg::LANES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+1:0] sin_val [eatrm_pkg::LANES],
  output logic signed [FRAC_BITS+1:0] cos_val [eatrm_pkg::LANES]
);
  import eatrm_pkg::*;

  localparam int W    = FRAC_BITS + 2;
  localparam int DROP = 32 - FRAC_BITS;
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (DROP - 1);
  localparam logic signed [XW-1:0] ONE  = XW'(1) <<< FRAC_BITS;

  logic signed [XW-1:0] c_raw [LANES];
  logic signed [XW-1:0] s_raw [LANES];
  logic signed [XW-1:0] c_rnd [LANES];
  logic signed [XW-1:0] s_rnd [LANES];
  logic signed [W-1:0]  sin_next [LANES];
  logic signed [W-1:0]  cos_next [LANES];

  assign in_ready = !out_valid || out_ready;

  // swap and negate by quarter turn, round, clamp
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      case (in_lane[k].q)
        2'd1: begin
          c_raw[k] = -in_lane[k].y;
          s_raw[k] = in_lane[k].x;
        end
        2'd2: begin
          c_raw[k] = -in_lane[k].x;
          s_raw[k] = -in_lane[k].y;
        end
        2'd3: begin
          c_raw[k] = in_lane[k].y;
          s_raw[k] = -in_lane[k].x;
        end
        default: begin
          c_raw[k] = in_lane[k].x;
          s_raw[k] = in_lane[k].y;
        end
      endcase
      c_rnd[k] = (c_raw[k] + HALF) >>> DROP;
      s_rnd[k] = (s_raw[k] + HALF) >>> DROP;
      if (c_rnd[k] > ONE) c_rnd[k] = ONE;
      if (c_rnd[k] < -ONE) c_rnd[k] = -ONE;
      if (s_rnd[k] > ONE) s_rnd[k] = ONE;
      if (s_rnd[k] < -ONE) s_rnd[k] = -ONE;
      cos_next[k] = c_rnd[k][W-1:0];
      sin_next[k] = s_rnd[k][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sin_val <= sin_next;
      cos_val <= cos_next;
    end
  end
endmodule

/* rtl/core/eatrm_matrix.sv */
// four-stage product and rounding pipeline for the nine entries
module eatrm_matrix #(
  parameter int FRAC_BITS = eatrm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FRAC_BITS+1:0] sin_val [eatrm_pkg::LANES],
  input  logic signed [FRAC_BITS+1:0] cos_val [eatrm_pkg::LANES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [eatrm_pkg::OUT_W-1:0] m_ent [9]
);
  import eatrm_pkg::*;

  localparam int W = FRAC_BITS + 2;
  localparam int P = 2 * W;
  localparam int S = 2 * W + 1;
  localparam logic signed [S-1:0] HALF = S'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [S-1:0] ONE  = S'(1) <<< FRAC_BITS;

  // round a double-precision value back to frac bits and clamp
  function automatic logic signed [W-1:0] rnd(input logic signed [S-1:0] v);
    logic signed [S-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    return t[W-1:0];
  endfunction

  logic v1, v2, v3, rd1, rd2, rd3;

  // stage 1 registers
  logic signed [P-1:0] p_spsr, p_spcr, p_cycp, p_sycp, p_cpsr, p_cpcr;
  logic signed [W-1:0] cy1, sy1, cr1, sr1, nsp1;
  // stage 2 registers
  logic signed [W-1:0] spsr2, spcr2, cy2, sy2, cr2, sr2, e0_2, e3_2, e6_2, e7_2, e8_2;
  // stage 3 registers
  logic signed [P-1:0] q_cyspsr, q_sycr, q_cyspcr, q_sysr, q_syspsr, q_cycr, q_syspcr, q_cysr;
  logic signed [W-1:0] e0_3, e3_3, e6_3, e7_3, e8_3;

  assign rd3      = !v3 || !out_valid || out_ready;
  assign rd2      = !v2 || rd3;
  assign rd1      = !v1 || rd2;
  assign in_ready = rd1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd1) v1 <= in_valid;
      if (rd2) v2 <= v1;
      if (rd3) v3 <= v2;
      if (!out_valid || out_ready) out_valid <= v3;
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (rd1 && in_valid) begin
      p_spsr <= sin_val[1] * sin_val[0];
      p_spcr <= sin_val[1] * cos_val[0];
      p_cycp <= cos_val[2] * cos_val[1];
      p_sycp <= sin_val[2] * cos_val[1];
      p_cpsr <= cos_val[1] * sin_val[0];
      p_cpcr <= cos_val[1] * cos_val[0];
      cy1    <= cos_val[2];
      sy1    <= sin_val[2];
      cr1    <= cos_val[0];
      sr1    <= sin_val[0];
      nsp1   <= -sin_val[1];
    end
  end

  // round the first products
  always_ff @(posedge clk) begin
    if (rd2 && v1) begin
      spsr2 <= rnd(S'(p_spsr));
      spcr2 <= rnd(S'(p_spcr));
      e0_2  <= rnd(S'(p_cycp));
      e3_2  <= rnd(S'(p_sycp));
      e7_2  <= rnd(S'(p_cpsr));
      e8_2  <= rnd(S'(p_cpcr));
      e6_2  <= nsp1;
      cy2   <= cy1;
      sy2   <= sy1;
      cr2   <= cr1;
      sr2   <= sr1;
    end
  end

  // second products
  always_ff @(posedge clk) begin
    if (rd3 && v2) begin
      q_cyspsr <= cy2 * spsr2;
      q_sycr   <= sy2 * cr2;
      q_cyspcr <= cy2 * spcr2;
      q_sysr   <= sy2 * sr2;
      q_syspsr <= sy2 * spsr2;
      q_cycr   <= cy2 * cr2;
      q_syspcr <= sy2 * spcr2;
      q_cysr   <= cy2 * sr2;
      e0_3 <= e0_2;
      e3_3 <= e3_2;
      e6_3 <= e6_2;
      e7_3 <= e7_2;
      e8_3 <= e8_2;
    end
  end

  // sums, rounding and output register
  always_ff @(posedge clk) begin
    if ((!out_valid || out_ready) && v3) begin
      m_ent[0] <= OUT_W'(e0_3);
      m_ent[1] <= OUT_W'(rnd(S'(q_cyspsr) - S'(q_sycr)));
      m_ent[2] <= OUT_W'(rnd(S'(q_cyspcr) + S'(q_sysr)));
      m_ent[3] <= OUT_W'(e3_3);
      m_ent[4] <= OUT_W'(rnd(S'(q_syspsr) + S'(q_cycr)));
      m_ent[5] <= OUT_W'(rnd(S'(q_syspcr) - S'(q_cysr)));
      m_ent[6] <= OUT_W'(e6_3);
      m_ent[7] <= OUT_W'(e7_3);
      m_ent[8] <= OUT_W'(e8_3);
    end
  end
endmodule

/* rtl/core/euler_angles_to_rotation_matrix.sv */
// roll-pitch-yaw angles to 3x3 rotation matrix, top level
//
// channel  dir  fields (low bit up)
// s_*      in   tdata: roll_angle, pitch_angle, yaw_angle
// m_*      out  tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
//
// one beat per cycle while m_tready is high; the path is registered in 32 cordic cells,
// one quadrant and rounding stage and four product stages.
// rst is synchronous and clears every valid bit; no data is reset.
// each stage holds its beat while the next is full, so bubbles close up
// and s_tready falls only when the whole chain is full and m_tready is low.
`include "euler_angles_to_rotation_matrix_defines.svh"
module euler_angles_to_rotation_matrix #(
  parameter int ANGLE_BITS = eatrm_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = eatrm_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // roll_angle, pitch_angle, yaw_angle, zero padding
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]         s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [9*eatrm_pkg::OUT_W-1:0]             m_tdata
);
  import eatrm_pkg::*;

  localparam int W = FRAC_BITS + 2;

  lane_t cell_lane [CORDIC_STEPS+1][LANES];
  logic  cell_valid [CORDIC_STEPS+1];
  logic  cell_ready [CORDIC_STEPS+1];

  logic signed [W-1:0] sin_val [LANES];
  logic signed [W-1:0] cos_val [LANES];
  logic fin_valid, fin_ready;
  logic [OUT_W-1:0] m_ent [9];

  logic [31:0] a32 [LANES];
  logic [32:0] a_rnd [LANES];

  // widen angles to a 32-bit turn, split off the nearest quarter turn
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      a32[k]   = {s_tdata[k*ANGLE_BITS +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      a_rnd[k] = {1'b0, a32[k]} + 33'h020000000;
      cell_lane[0][k].q = a_rnd[k][31:30];
      cell_lane[0][k].z = ZW'($signed({1'b0, a_rnd[k][29:0]})) - ZW'(33'sh020000000);
      cell_lane[0][k].x = INV_GAIN;
      cell_lane[0][k].y = '0;
    end
  end

  assign cell_valid[0] = s_tvalid;
  assign s_tready      = cell_ready[0];

  // cordic chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    eatrm_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_lane   (cell_lane[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_lane  (cell_lane[i+1])
    );
  end

  eatrm_sincos_fin #(.FRAC_BITS(FRAC_BITS)) u_fin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid[CORDIC_STEPS]),
    .in_ready  (cell_ready[CORDIC_STEPS]),
    .in_lane   (cell_lane[CORDIC_STEPS]),
    .out_valid (fin_valid),
    .out_ready (fin_ready),
    .sin_val   (sin_val),
    .cos_val   (cos_val)
  );

  eatrm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_valid),
    .in_ready  (fin_ready),
    .sin_val   (sin_val),
    .cos_val   (cos_val),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .m_ent     (m_ent)
  );

  // pack the nine entries
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_tdata[k*OUT_W +: OUT_W] = m_ent[k];
    end
  end

  // checks
  `ERM_ASSERT_NOW(a_full_only_when_stalled, !s_tready, m_tvalid && !m_tready,
                  "input blocked while output free")
  `ERM_ASSERT_NOW(a_m00_range, m_tvalid && (FRAC_BITS <= 14),
                  ($signed(m_tdata[15:0]) <= $signed(16'(1 << FRAC_BITS))) &&
                  ($signed(m_tdata[15:0]) >= -$signed(16'(1 << FRAC_BITS))),
                  "m00 out of range")
endmodule
